// ===== sv/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, constants and helpers of the prime factor counter
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

	// result count field
	localparam int unsigned COUNT_W = 5;

	typedef logic [COUNT_W-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	// first odd trial divisor and the limit above which a leftover is prime
	localparam int unsigned FIRST_ODD   = 3;
	localparam int unsigned PRIME_FLOOR = 2;
	localparam int unsigned ODD_STEP    = 2;

	// sequencer state codes
	localparam int unsigned STATE_W = 3;

	typedef logic [STATE_W-1:0] state_t;

	localparam state_t S_IDLE  = 3'd0;
	localparam state_t S_TWO   = 3'd1;
	localparam state_t S_ISSUE = 3'd2;
	localparam state_t S_WAIT  = 3'd3;
	localparam state_t S_FIN   = 3'd4;

	// saturating increment of the count
	function automatic count_t sat_inc(input count_t c);
		count_t r;
		if (c == COUNT_MAX) begin
			r = c;
		end else begin
			r = c + count_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pfc_div.sv =====
// ----------------------------------------------------------------------------
// pfc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_div #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);

	localparam int unsigned STEP_W = $clog2(W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      acc_q;
	logic [W-1:0]      quo_q;
	logic [W-1:0]      dsr_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {acc_q, quo_q[W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			step_q <= step_q + STEP_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = acc_q;

endmodule

`default_nettype wire

// ===== sv/prime_factor_count.sv =====
// ----------------------------------------------------------------------------
// prime_factor_count
// counts the prime factors of an unsigned integer, with multiplicity,
// by trial division on one shared bit-serial divider
// ----------------------------------------------------------------------------
//
//  channel  signals                              direction
//  in       in_valid, in_stall, value            item in, stall driven here
//  out      out_valid, out_stall, factor_count,  item out, stall driven
//           zero_input                           by the receiver
//
//  one item at a time: in_stall is high from acceptance until the result
//  has been written to the output register. factors of two are stripped at
//  one per cycle; every trial division then runs in the shared divider,
//  so a 32-bit prime near the top of the range needs about 32k divisions,
//  while typical inputs finish far sooner. a zero input goes straight to
//  the final state, which writes it to the output register once the
//  output is free. reset clears the sequencer and the output valid; no
//  clearing pass. a held output does not block a new item: only the final
//  write waits.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_factor_count #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output pfc_pkg::count_t             factor_count,
	output logic                        zero_input
);

	localparam int unsigned W = VALUE_WIDTH;

	// sequencer control
	pfc_pkg::state_t state_q, state_d;
	logic            bound_q, bound_d;     // next division also tests d*d <= rest
	logic            out_valid_q, out_valid_d;

	// working values
	logic [W-1:0]    rest_q, rest_d;       // value left to factor
	logic [W-1:0]    div_q, div_d;         // current odd trial divisor
	pfc_pkg::count_t cnt_q, cnt_d;         // saturating factor count
	logic            zero_q, zero_d;

	// output register
	pfc_pkg::count_t res_cnt_q;
	logic            res_zero_q;
	logic            res_load;

	// shared divider
	logic         div_start;
	logic         div_done;
	logic [W-1:0] div_quot;
	logic [W-1:0] div_rem;

	logic accept;
	logic out_free;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == pfc_pkg::S_ISSUE);

	pfc_div #(
		.W(W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rest_q),
		.divisor (div_q),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// sequencer: strip twos, then odd divisors while d <= rest / d
	always_comb begin
		state_d     = state_q;
		bound_d     = bound_q;
		rest_d      = rest_q;
		div_d       = div_q;
		cnt_d       = cnt_q;
		zero_d      = zero_q;
		res_load    = 1'b0;
		out_valid_d = out_valid_q;

		// the receiver takes the held item
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			pfc_pkg::S_IDLE: begin
				if (accept) begin
					rest_d = value;
					cnt_d  = '0;
					zero_d = (value == '0);
					// zero has no factorization: answer at once
					state_d = (value == '0) ? pfc_pkg::S_FIN : pfc_pkg::S_TWO;
				end
			end
			pfc_pkg::S_TWO: begin
				if (!rest_q[0]) begin
					cnt_d  = pfc_pkg::sat_inc(cnt_q);
					rest_d = rest_q >> 1;
				end else begin
					div_d   = W'(pfc_pkg::FIRST_ODD);
					bound_d = 1'b1;
					state_d = pfc_pkg::S_ISSUE;
				end
			end
			pfc_pkg::S_ISSUE: begin
				state_d = pfc_pkg::S_WAIT;
			end
			pfc_pkg::S_WAIT: begin
				if (div_done) begin
					if (bound_q && (div_q > div_quot)) begin
						// divisor passed the square root: leftover above two is prime
						if (rest_q > W'(pfc_pkg::PRIME_FLOOR)) begin
							cnt_d = pfc_pkg::sat_inc(cnt_q);
						end
						state_d = pfc_pkg::S_FIN;
					end else if (div_rem == '0) begin
						// divisor divides: count it and try the same divisor again
						cnt_d   = pfc_pkg::sat_inc(cnt_q);
						rest_d  = div_quot;
						bound_d = 1'b0;
						state_d = pfc_pkg::S_ISSUE;
					end else begin
						div_d   = div_q + W'(pfc_pkg::ODD_STEP);
						bound_d = 1'b1;
						state_d = pfc_pkg::S_ISSUE;
					end
				end
			end
			pfc_pkg::S_FIN: begin
				if (out_free) begin
					res_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = pfc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfc_pkg::S_IDLE;
			bound_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			bound_q     <= bound_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rest_q <= rest_d;
		div_q  <= div_d;
		cnt_q  <= cnt_d;
		zero_q <= zero_d;
		if (res_load) begin
			res_cnt_q  <= cnt_q;
			res_zero_q <= zero_q;
		end
	end

	assign in_stall     = (state_q != pfc_pkg::S_IDLE);
	assign out_valid    = out_valid_q;
	assign factor_count = res_cnt_q;
	assign zero_input   = res_zero_q;

`ifndef SYNTH

	// an accepted item keeps the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// the divider only finishes while the sequencer waits for it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pfc_pkg::S_WAIT)
		else $error("divider finished outside the wait state");

	// a new result only appears out of the final state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == pfc_pkg::S_FIN)
		else $error("result appeared without finishing an item");

	// a zero input never reports factors
	a_zero_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input |-> factor_count == '0)
		else $error("zero input reported a nonzero count");

`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for prime_factor_count: every accepted value is run
// through a trial-division predictor and the factor count and zero flag of
// each result item are checked in order against it
// ----------------------------------------------------------------------------

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VW = 32;

	// cycles the shared divider spends on one trial division
	localparam int unsigned DIV_CYCLES = VW + 2;

	// random values costing more trial divisions than this are drawn again,
	// which keeps the run well clear of the slowest primes near the top
	localparam int unsigned TRIAL_CAP = 400;

	localparam int unsigned RANDOM_ITEMS = 77;

	// expected content of one result item
	typedef struct packed {
		pfc_pkg::count_t count;
		logic            zero;
	} omega_result_t;

	// one input item waiting to be sent, with the idling of its phase
	typedef struct {
		logic [VW-1:0] value;
		int unsigned   send_pct;
		int unsigned   recv_pct;
		bit            drain;
	} pending_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [VW-1:0]         value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pfc_pkg::count_t       factor_count;
	logic                  zero_input;

	pending_item_t         item_queue[$];
	omega_result_t         expected_omega[$];

	// handshake counts, each written by one process only with nonblocking
	// assignments so the other process always sees last cycle's value
	int unsigned           items_accepted = 0;
	int unsigned           results_seen = 0;

	int unsigned           recv_pct = 0;
	int unsigned           err_count = 0;
	longint unsigned       cycle_count = 0;
	longint unsigned       cycle_budget = 0;
	longint unsigned       cycle_limit = 64'd1_000_000;

	prime_factor_count #(
		.VALUE_WIDTH(VW)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.factor_count(factor_count),
		.zero_input  (zero_input)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// big omega by trial division; also returns how many remainder tests
	// the search takes, which sets the block's run time for this value
	function automatic omega_result_t predict_omega(input logic [VW-1:0] v,
			output int unsigned trials);
		omega_result_t r;
		logic [63:0]   rest;
		logic [63:0]   d;
		int unsigned   n;
		trials = 0;
		n = 0;
		r.zero = 1'b0;
		r.count = '0;
		if (v == '0) begin
			// zero has no factorization, flag it instead of looping
			r.zero = 1'b1;
			return r;
		end
		rest = 64'(v);
		// strip factors of two
		while (rest[0] == 1'b0) begin
			n++;
			rest = rest >> 1;
		end
		// odd divisors while d*d does not exceed what is left
		for (d = 3; d <= rest / d; d += 2) begin
			while (rest % d == 0) begin
				n++;
				trials++;
				rest = rest / d;
			end
			trials++;
		end
		// a leftover above two is one more prime
		if (rest > 2) begin
			n++;
		end
		r.count = (n > pfc_pkg::COUNT_MAX) ? pfc_pkg::COUNT_MAX : pfc_pkg::count_t'(n);
		return r;
	endfunction

	// queue one item and grow the time allowance by its worst-case cost
	task automatic enqueue_value(input logic [VW-1:0] v, input int unsigned sp,
			input int unsigned rp, input bit drain);
		pending_item_t it;
		omega_result_t unused;
		int unsigned   trials;
		unused = predict_omega(v, trials);
		it.value = v;
		it.send_pct = sp;
		it.recv_pct = rp;
		it.drain = drain;
		item_queue.insert(item_queue.size(), it);
		cycle_budget += longint'(DIV_CYCLES) * trials + 2 * VW + 60;
	endtask

	task automatic flag_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// driver: presents queued items, holds them while stalled, records the
	// expected result of each item at the edge where it is taken
	always @(posedge clk or negedge arst_n) begin
		pending_item_t nxt;
		int unsigned   acc_now;
		logic          launch;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			launch = 1'b0;
			acc_now = items_accepted;
			if (in_valid && !in_stall) begin
				int unsigned   unused_trials;
				omega_result_t exp_r;
				exp_r = predict_omega(value, unused_trials);
				expected_omega.insert(expected_omega.size(), exp_r);
				acc_now = items_accepted + 1;
				items_accepted <= acc_now;
			end
			// free to move on: nothing shown, or the shown item just went in
			if (!in_valid || !in_stall) begin
				if (item_queue.size() > 0) begin
					nxt = item_queue[0];
					launch = 1'b1;
					// a draining item waits until every result is back
					if (nxt.drain && acc_now != results_seen) begin
						launch = 1'b0;
					end
					if ($urandom_range(99) < nxt.send_pct) begin
						launch = 1'b0;
					end
				end
				if (launch) begin
					value <= nxt.value;
					recv_pct <= nxt.recv_pct;
					void'(item_queue.pop_front());
				end
				in_valid <= launch;
			end
		end
	end

	// monitor: random stall on the result side, compares each taken result
	// with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		omega_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_seen >= items_accepted) begin
					flag_mismatch($sformatf("result with no item pending: count %0d zero %0b",
						factor_count, zero_input));
				end else begin
					want = expected_omega.pop_front();
					if (factor_count !== want.count) begin
						flag_mismatch($sformatf("factor_count %0d, expected %0d",
							factor_count, want.count));
					end
					if (zero_input !== want.zero) begin
						flag_mismatch($sformatf("zero_input %0b, expected %0b",
							zero_input, want.zero));
					end
					results_seen <= results_seen + 1;
				end
			end
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	// watchdog, limit set from the per-item cost of the whole stimulus
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [VW-1:0] directed[$];
		logic [63:0]   acc;
		logic [VW-1:0] v;
		omega_result_t unused;
		int unsigned   trials;
		int unsigned   f;
		int unsigned   shape;
		int unsigned   sp;
		int unsigned   rp;
		bit            drain;

		// directed items: zero, one, small primes and powers, squares of
		// primes where the bound d*d <= rest is exactly met, the all-ones
		// and top-bit extremes, the largest counts the field can take, and a
		// prime that makes the odd search run to its bound
		directed = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd8, 32'd9, 32'd15,
			32'd25, 32'd49, 32'd210, 32'd65537, 32'd1042441, 32'd1048573,
			32'd3486784401, 32'hFFFF_FFFF, 32'h8000_0000, 32'hC000_0000,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_0000
		};
		foreach (directed[i]) begin
			enqueue_value(directed[i], 9, 66, 1'b0);
		end

		// random items in three idling phases: sender seldom idle and receiver
		// often stalling, then reversed, then no idling at all
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS / 3) begin
				sp = 9;
				rp = 66;
			end else if (i < 2 * RANDOM_ITEMS / 3) begin
				sp = 66;
				rp = 9;
			end else begin
				sp = 0;
				rp = 0;
			end
			// drain before each phase and now and then in between
			drain = (i == 0) || (i == RANDOM_ITEMS / 3) || (i == 2 * RANDOM_ITEMS / 3)
				|| ($urandom_range(99) < 5);
			shape = $urandom_range(99);
			if (shape < 35) begin
				// product of small factors filling most of the range
				acc = 64'd1;
				forever begin
					f = $urandom_range(300, 2);
					if (acc * f > 64'hFFFF_FFFF) begin
						break;
					end
					acc = acc * f;
				end
				v = acc[VW-1:0];
			end else if (shape < 65) begin
				// full-width random value, redrawn while too slow to factor
				do begin
					v = $urandom;
					unused = predict_omega(v, trials);
				end while (trials > TRIAL_CAP);
			end else if (shape < 80) begin
				v = VW'($urandom_range(1023, 0));
			end else if (shape < 92) begin
				// small nonzero value shifted up, may drop out to zero
				v = VW'($urandom_range(2047, 1)) << $urandom_range(31, 0);
			end else begin
				v = $urandom_range(1, 0) ? '0 : '1;
			end
			enqueue_value(v, sp, rp, drain);
		end

		cycle_limit = 4 * cycle_budget + 20000;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// settle at the falling edge so every handshake of the cycle is done
		do begin
			@(negedge clk);
		end while (item_queue.size() != 0 || in_valid || items_accepted != results_seen);

		// let a stray extra result show up if the block produces one
		repeat (2 * VW + 40) @(negedge clk);

		if (expected_omega.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", expected_omega.size()));
		end

		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
